### hw/rtl/bsg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsg_pkg
// Shared types and constants for the BMP stream to grayscale block.
// ----------------------------------------------------------------------------
package bsg_pkg;

  localparam int DIM_BITS_DEF = 16;

  // Width of the weighted color sum 299r + 587g + 114b
  localparam int LUMA_W = 18;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_HEADER    = 2'd1,
    KIND_BAD_SIG   = 2'd2,
    KIND_BAD_DEPTH = 2'd3
  } kind_t;

  // Result handed from the parser to the divide stage
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic              bypass;
    logic [LUMA_W-1:0] sum;
    logic [15:0]       width;
    logic [15:0]       height;
    logic              last;
  } mid_t;

endpackage
`default_nettype wire

### hw/rtl/bsg_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsg_parser
// Header capture, offset skip, pixel grouping and row padding; registers
// at most one pending result per accepted byte.
// ----------------------------------------------------------------------------
module bsg_parser import bsg_pkg::*; #(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       accept,
  input  logic [7:0] byte_in,
  input  logic       start_file,
  output mid_t       mid
);

  localparam int CNT_W = DIM_BITS - 1;

  localparam logic [5:0]        HDR_LAST = 6'd53;
  localparam logic [31:0]       HDR_LEN  = 32'd54;
  localparam logic [15:0]       BMP_SIG  = 16'h4D42;
  localparam logic [15:0]       DEPTH_8  = 16'd8;
  localparam logic [15:0]       DEPTH_24 = 16'd24;
  localparam logic [LUMA_W-1:0] COEF_R   = LUMA_W'(299);
  localparam logic [LUMA_W-1:0] COEF_G   = LUMA_W'(587);
  localparam logic [LUMA_W-1:0] COEF_B   = LUMA_W'(114);

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_HEADER = 6'b000010,
    PH_SKIP   = 6'b000100,
    PH_PIXEL  = 6'b001000,
    PH_PAD    = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  function automatic logic [15:0] sat16(input logic [31:0] raw);
    logic [15:0] r;
    if (raw[31]) begin
      r = (&raw[30:15]) ? raw[15:0] : 16'h8000;
    end else begin
      r = (|raw[30:15]) ? 16'h7FFF : raw[15:0];
    end
    return r;
  endfunction

  phase_t            phase, phase_next, phase_cur;
  logic [5:0]        header_count, header_count_next, hc_cur, rel;
  logic [15:0]       signature, signature_next;
  logic [31:0]       data_offset, data_offset_next;
  logic [31:0]       width_raw, width_raw_next;
  logic [31:0]       height_raw, height_raw_next;
  logic [15:0]       depth, depth_next;
  logic [31:0]       byte_position, byte_position_next;
  logic [CNT_W-1:0]  column_count, column_count_next;
  logic [CNT_W-1:0]  row_count, row_count_next;
  logic [1:0]        pad_count, pad_count_next;
  logic [1:0]        color_phase, color_phase_next;
  logic [LUMA_W-1:0] luma_acc, luma_acc_next;

  logic [CNT_W-1:0]  w_cnt, h_cnt;
  logic [CNT_W:0]    col_inc, row_inc;
  logic [1:0]        row_bytes, row_pad;
  logic              do_pixel, emit_pixel;
  mid_t              res;

  // Dimensions as pixel counts: zero when not positive, saturated when large
  assign w_cnt = width_raw[31] ? '0 :
                 (|width_raw[30:CNT_W]) ? {CNT_W{1'b1}} : width_raw[CNT_W-1:0];
  assign h_cnt = height_raw[31] ? '0 :
                 (|height_raw[30:CNT_W]) ? {CNT_W{1'b1}} : height_raw[CNT_W-1:0];

  assign col_inc   = {1'b0, column_count} + 1'b1;
  assign row_inc   = {1'b0, row_count} + 1'b1;
  assign row_bytes = (depth == DEPTH_24) ? 2'(w_cnt[1:0] * 2'd3) : w_cnt[1:0];
  assign row_pad   = 2'd0 - row_bytes;

  always_comb begin
    phase_cur = start_file ? PH_HEADER : phase;
    hc_cur    = start_file ? 6'd0 : header_count;
    rel       = 6'd0;

    phase_next         = phase_cur;
    header_count_next  = hc_cur;
    signature_next     = start_file ? 16'd0 : signature;
    data_offset_next   = start_file ? 32'd0 : data_offset;
    width_raw_next     = start_file ? 32'd0 : width_raw;
    height_raw_next    = start_file ? 32'd0 : height_raw;
    depth_next         = start_file ? 16'd0 : depth;
    byte_position_next = start_file ? 32'd0 : byte_position;
    column_count_next  = start_file ? '0 : column_count;
    row_count_next     = start_file ? '0 : row_count;
    pad_count_next     = start_file ? 2'd0 : pad_count;
    color_phase_next   = start_file ? 2'd0 : color_phase;
    luma_acc_next      = luma_acc;

    do_pixel   = 1'b0;
    emit_pixel = 1'b0;
    res        = '0;

    case (phase_cur)
      PH_HEADER: begin
        if (hc_cur < 6'd2) begin
          signature_next[{hc_cur[0], 3'b000} +: 8] = byte_in;
        end else if (hc_cur >= 6'd10 && hc_cur < 6'd14) begin
          rel = hc_cur - 6'd10;
          data_offset_next[{rel[1:0], 3'b000} +: 8] = byte_in;
        end else if (hc_cur >= 6'd18 && hc_cur < 6'd22) begin
          rel = hc_cur - 6'd18;
          width_raw_next[{rel[1:0], 3'b000} +: 8] = byte_in;
        end else if (hc_cur >= 6'd22 && hc_cur < 6'd26) begin
          rel = hc_cur - 6'd22;
          height_raw_next[{rel[1:0], 3'b000} +: 8] = byte_in;
        end else if (hc_cur >= 6'd28 && hc_cur < 6'd30) begin
          rel = hc_cur - 6'd28;
          depth_next[{rel[0], 3'b000} +: 8] = byte_in;
        end
        if (hc_cur != HDR_LAST) begin
          header_count_next = hc_cur + 6'd1;
        end else begin
          byte_position_next = HDR_LEN;
          res.valid  = 1'b1;
          res.last   = 1'b1;
          phase_next = PH_DONE;
          if (signature != BMP_SIG) begin
            res.kind = KIND_BAD_SIG;
          end else begin
            res.width  = sat16(width_raw);
            res.height = sat16(height_raw);
            if (depth != DEPTH_8 && depth != DEPTH_24) begin
              res.kind = KIND_BAD_DEPTH;
            end else begin
              res.kind = KIND_HEADER;
              if (w_cnt != '0 && h_cnt != '0) begin
                res.last   = 1'b0;
                phase_next = PH_SKIP;
              end
            end
          end
        end
      end
      PH_SKIP: begin
        // Offsets below the header length never hold here: position starts at 54
        if (byte_position < data_offset) begin
          byte_position_next = byte_position + 32'd1;
        end else begin
          phase_next = PH_PIXEL;
          do_pixel   = 1'b1;
        end
      end
      PH_PIXEL: begin
        do_pixel = 1'b1;
      end
      PH_PAD: begin
        pad_count_next = pad_count - 2'd1;
        if (pad_count == 2'd1) begin
          phase_next = PH_PIXEL;
        end
      end
      default: begin
      end
    endcase

    if (do_pixel) begin
      if (depth == DEPTH_24) begin
        case (color_phase)
          2'd0: begin
            luma_acc_next    = COEF_B * LUMA_W'(byte_in);
            color_phase_next = 2'd1;
          end
          2'd1: begin
            luma_acc_next    = luma_acc + COEF_G * LUMA_W'(byte_in);
            color_phase_next = 2'd2;
          end
          default: begin
            color_phase_next = 2'd0;
            res.sum          = luma_acc + COEF_R * LUMA_W'(byte_in);
            emit_pixel       = 1'b1;
          end
        endcase
      end else begin
        res.bypass = 1'b1;
        res.sum    = LUMA_W'(byte_in);
        emit_pixel = 1'b1;
      end
    end

    if (emit_pixel) begin
      res.valid = 1'b1;
      res.kind  = KIND_PIXEL;
      column_count_next = col_inc[CNT_W-1:0];
      if (col_inc >= {1'b0, w_cnt}) begin
        column_count_next = '0;
        row_count_next    = row_inc[CNT_W-1:0];
        if (row_inc >= {1'b0, h_cnt}) begin
          res.last   = 1'b1;
          phase_next = PH_DONE;
        end else begin
          pad_count_next = row_pad;
          if (row_pad != 2'd0) begin
            phase_next = PH_PAD;
          end
        end
      end
    end

    // Only a byte taken this cycle makes a result
    res.valid = res.valid & accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      header_count  <= '0;
      signature     <= '0;
      data_offset   <= '0;
      width_raw     <= '0;
      height_raw    <= '0;
      depth         <= '0;
      byte_position <= '0;
      column_count  <= '0;
      row_count     <= '0;
      pad_count     <= '0;
      color_phase   <= '0;
      luma_acc      <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      signature     <= signature_next;
      data_offset   <= data_offset_next;
      width_raw     <= width_raw_next;
      height_raw    <= height_raw_next;
      depth         <= depth_next;
      byte_position <= byte_position_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      pad_count     <= pad_count_next;
      color_phase   <= color_phase_next;
      luma_acc      <= luma_acc_next;
    end
  end

  // Hold the pending result while the output side stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid <= 1'b0;
    end else if (en) begin
      mid <= res;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bsg_luma_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsg_luma_div
// Divides the weighted color sum by 1000 through a reciprocal multiply,
// passes bypass bytes through unchanged, and registers the finished result item.
// ----------------------------------------------------------------------------
module bsg_luma_div import bsg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  mid_t        mid,
  output logic        out_valid,
  output kind_t       kind,
  output logic [7:0]  gray,
  output logic [15:0] img_width,
  output logic [15:0] img_height,
  output logic        last
);

  // floor(x / 1000) == (x * ceil(2^27 / 1000)) >> 27 for every x below 2^18
  localparam int          DIV_SHIFT = 27;
  localparam int          PROD_W    = LUMA_W + 18;
  localparam logic [PROD_W-1:0] DIV_MULT = PROD_W'(134218);

  logic [PROD_W-1:0] prod;
  logic [7:0]        quot;

  assign prod = PROD_W'(mid.sum) * DIV_MULT;
  assign quot = prod[DIV_SHIFT +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= mid.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind       <= mid.kind;
      gray       <= mid.bypass ? mid.sum[7:0] : quot;
      img_width  <= mid.width;
      img_height <= mid.height;
      last       <= mid.last;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bmp_stream_to_grayscale_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_stream_to_grayscale_top
// BMP byte stream in, header info and grayscale pixel items out.
// ----------------------------------------------------------------------------
// Input channel: one file byte per item in s_tdata; s_tuser high marks the
// first byte of a file and restarts the parse. Output channel: one result
// item per pixel, plus one item after the 54-byte header (header info, bad
// signature or unsupported depth); m_tuser carries the kind, m_tlast marks
// the final item of the file. Bytes before the first start, padding and
// bytes after the final item produce no output.
// Throughput is one byte per cycle while the receiver does not stall.
// After its byte is accepted, a result passes through the parser, which
// registers the weighted color sum, then the divide-by-1000 multiply feeds
// the output register. When the receiver stalls with an item waiting, both
// stages hold and s_tready drops in the same cycle; an empty output
// register keeps the input open. Reset returns the parser to idle, awaiting
// a start byte, and empties both stages.
// ----------------------------------------------------------------------------
module bmp_stream_to_grayscale_top import bsg_pkg::*; #(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tuser,   // [0] start_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] gray, [23:8] img_width, [39:24] img_height
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  logic  en;
  logic  accept;
  mid_t  mid;
  kind_t kind;
  logic [7:0]  gray;
  logic [15:0] img_width;
  logic [15:0] img_height;

  // Advance the pipeline whenever the output register is free or taken
  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid & en;

  bsg_parser #(
    .DIM_BITS (DIM_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .accept     (accept),
    .byte_in    (s_tdata),
    .start_file (s_tuser),
    .mid        (mid)
  );

  bsg_luma_div u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .mid        (mid),
    .out_valid  (m_tvalid),
    .kind       (kind),
    .gray       (gray),
    .img_width  (img_width),
    .img_height (img_height),
    .last       (m_tlast)
  );

  assign m_tdata = {img_height, img_width, gray};
  assign m_tuser = kind;

endmodule
`default_nettype wire
